>>> hw/rtl/pfba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfba_pkg
// Shared types and sizing constants of the page frame bitmap allocator.
// ----------------------------------------------------------------------------
package pfba_pkg;

    // table capacity and page size (page size is a power of two)
    localparam int NUM_PAGES  = 1024;
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_BYTES = 1 << PAGE_SHIFT;

    localparam int ADDR_W   = 64;
    localparam int PCOUNT_W = 11;
    localparam int CNT_W    = $clog2(NUM_PAGES + 1);
    localparam int IDX_W    = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int SPAN_W   = ADDR_W - PAGE_SHIFT;

    localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'(PAGE_BYTES - 1);
    localparam logic [ADDR_W-1:0] PAGE_STEP = ADDR_W'(PAGE_BYTES);
    localparam logic [CNT_W-1:0]  CAPACITY  = CNT_W'(NUM_PAGES);

    // request operation codes
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_ALLOC = 2'd2,
        OP_FREE  = 2'd3
    } t_op;

    // one table entry: used mark and page address
    typedef struct packed {
        logic              used;
        logic [ADDR_W-1:0] addr;
    } t_entry;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_SPAN,
        ST_TAKE,
        ST_FILL,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage : pfba_pkg
`default_nettype wire

>>> hw/rtl/pfba_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfba_req_if / pfba_rsp_if
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------
interface pfba_req_if
    import pfba_pkg::*;
();
    logic              valid;
    logic              ready;
    t_op               op;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] region_length;

    modport source (output valid, op, address, region_length, input ready);
    modport sink   (input valid, op, address, region_length, output ready);
endinterface : pfba_req_if

interface pfba_rsp_if
    import pfba_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   page_addr;
    logic                ok;
    logic [PCOUNT_W-1:0] page_count;

    modport source (output valid, page_addr, ok, page_count, input ready);
    modport sink   (input valid, page_addr, ok, page_count, output ready);
endinterface : pfba_rsp_if
`default_nettype wire

>>> hw/rtl/page_frame_bitmap_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator
// Physical page frame allocator over a table of page addresses with one used
// mark per entry, held together in a single-port synchronous memory.
//
//   channel  | dir | transfer
//   ---------+-----+------------------------------------------------
//   i_req    | in  | op, address, region_length
//   o_rsp    | out | page_addr, ok, page_count (one per request)
//
// clear resets the fill count; add region aligns the region, counts its
// whole pages, clips them to the room left and appends them; allocate and
// free walk the entries in index order up to a match or the fill count;
// the single memory port moves one entry per cycle.
// one request is worked at a time; the next one is taken while the response
// waits in the output register.
// no clearing pass after reset: entries at or past the fill count are never
// read, and each append writes its entry with a clear used mark.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator
    import pfba_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    pfba_req_if.sink   i_req,
    pfba_rsp_if.source o_rsp
);

    // entry memory
    t_entry mem [NUM_PAGES];

    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    logic [ADDR_W-1:0]   r_key, n_key;
    logic [ADDR_W-1:0]   r_len, n_len;
    logic [ADDR_W-1:0]   r_start, n_start;
    logic [ADDR_W-1:0]   r_end, n_end;
    logic [SPAN_W-1:0]   r_span, n_span;
    logic [ADDR_W-1:0]   r_cur, n_cur;
    logic [CNT_W-1:0]    r_left, n_left;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic                r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]    r_rd_idx, n_rd_idx;
    t_entry              r_rd_data;
    logic [ADDR_W-1:0]   r_res_page, n_res_page;
    logic                r_res_ok, n_res_ok;
    logic                r_out_vld, n_out_vld;
    logic [ADDR_W-1:0]   r_out_page, n_out_page;
    logic                r_out_ok, n_out_ok;
    logic [PCOUNT_W-1:0] r_out_cnt, n_out_cnt;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    t_entry            wr_data;
    logic              out_free;
    logic              issue;
    logic              hit;
    logic [CNT_W-1:0]  room;

    assign i_req.ready      = (r_state == ST_IDLE);
    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.page_addr  = r_out_page;
    assign o_rsp.ok         = r_out_ok;
    assign o_rsp.page_count = r_out_cnt;

    assign out_free = !r_out_vld || o_rsp.ready;
    assign issue    = (r_idx < r_count);
    assign room     = CAPACITY - r_count;
    assign hit      = (r_op == OP_ALLOC) ? !r_rd_data.used : (r_rd_data.addr == r_key);

    // memory port: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_len      <= n_len;
        r_start    <= n_start;
        r_end      <= n_end;
        r_span     <= n_span;
        r_cur      <= n_cur;
        r_left     <= n_left;
        r_idx      <= n_idx;
        r_rd_idx   <= n_rd_idx;
        r_res_page <= n_res_page;
        r_res_ok   <= n_res_ok;
        r_out_page <= n_out_page;
        r_out_ok   <= n_out_ok;
        r_out_cnt  <= n_out_cnt;
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_key      = r_key;
        n_len      = r_len;
        n_start    = r_start;
        n_end      = r_end;
        n_span     = r_span;
        n_cur      = r_cur;
        n_left     = r_left;
        n_count    = r_count;
        n_idx      = r_idx;
        n_rd_vld   = 1'b0;
        n_rd_idx   = r_rd_idx;
        n_res_page = r_res_page;
        n_res_ok   = r_res_ok;
        n_out_vld  = r_out_vld && !o_rsp.ready;
        n_out_page = r_out_page;
        n_out_ok   = r_out_ok;
        n_out_cnt  = r_out_cnt;
        rd_en      = 1'b0;
        rd_addr    = r_idx[IDX_W-1:0];
        wr_en      = 1'b0;
        wr_addr    = r_count[IDX_W-1:0];
        wr_data    = '{used: 1'b0, addr: r_cur};

        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_op       = i_req.op;
                    n_key      = i_req.address;
                    n_len      = i_req.region_length;
                    n_idx      = '0;
                    n_res_page = '0;
                    n_res_ok   = 1'b0;
                    unique case (i_req.op)
                        OP_CLEAR: begin
                            n_count  = '0;
                            n_res_ok = 1'b1;
                            n_state  = ST_DONE;
                        end
                        OP_ADD:   n_state = ST_ALIGN;
                        OP_ALLOC: n_state = ST_SCAN;
                        OP_FREE:  n_state = ST_SCAN;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end

            // start aligned up, end aligned down, both wrapping at 64 bits
            ST_ALIGN: begin
                n_start = (r_key + PAGE_MASK) & ~PAGE_MASK;
                n_end   = (r_key + r_len) & ~PAGE_MASK;
                n_state = ST_SPAN;
            end

            // whole pages in the region
            ST_SPAN: begin
                n_span  = (r_start < r_end) ? SPAN_W'((r_end - r_start) >> PAGE_SHIFT) : '0;
                n_cur   = r_start;
                n_state = ST_TAKE;
            end

            // clip to the room left in the table
            ST_TAKE: begin
                n_res_ok = (r_span <= SPAN_W'(room));
                n_left   = (r_span < SPAN_W'(room)) ? CNT_W'(r_span) : room;
                n_state  = ST_FILL;
            end

            // append one free entry per cycle
            ST_FILL: begin
                if (r_left == '0) begin
                    n_state = ST_DONE;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    n_cur   = r_cur + PAGE_STEP;
                    n_left  = r_left - CNT_W'(1);
                end
            end

            // walk entries in index order, check one per cycle
            ST_SCAN: begin
                if (r_rd_vld && hit) begin
                    wr_en      = 1'b1;
                    wr_addr    = r_rd_idx;
                    wr_data    = '{used: (r_op == OP_ALLOC), addr: r_rd_data.addr};
                    n_res_ok   = 1'b1;
                    n_res_page = (r_op == OP_ALLOC) ? r_rd_data.addr : '0;
                    n_state    = ST_DONE;
                end else if (!r_rd_vld && !issue) begin
                    n_state = ST_DONE;
                end else if (issue) begin
                    rd_en    = 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_idx[IDX_W-1:0];
                    n_idx    = r_idx + CNT_W'(1);
                end
            end

            // hand the result to the output register
            ST_DONE: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_page = r_res_page;
                    n_out_ok   = r_res_ok;
                    n_out_cnt  = PCOUNT_W'(r_count);
                    n_state    = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

endmodule : page_frame_bitmap_allocator
`default_nettype wire

>>> hw/rtl/pfba_check.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfba_check
// Port-level checks of the page frame bitmap allocator, bound to the top.
// ----------------------------------------------------------------------------
module pfba_check
    import pfba_pkg::*;
(
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_req_valid,
    input wire                i_req_ready,
    input wire                i_rsp_valid,
    input wire                i_rsp_ready,
    input wire [ADDR_W-1:0]   i_rsp_page_addr,
    input wire                i_rsp_ok,
    input wire [PCOUNT_W-1:0] i_rsp_page_count
);

    logic       req_xfer;
    logic       rsp_xfer;
    logic [1:0] r_pend;
    logic [1:0] n_pend;

    assign req_xfer = i_req_valid && i_req_ready;
    assign rsp_xfer = i_rsp_valid && i_rsp_ready;

    // requests taken but not yet answered
    always_comb begin
        n_pend = r_pend;
        if (req_xfer && !rsp_xfer) begin
            n_pend = r_pend + 2'd1;
        end else if (!req_xfer && rsp_xfer) begin
            n_pend = r_pend - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
        end else begin
            r_pend <= n_pend;
        end
    end

    // a response stays offered until its transfer
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_page_addr))
        else $error("response dropped or changed while stalled");

    // every response answers a taken request
    a_rsp_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> r_pend != 2'd0)
        else $error("response without a request");

    // at most one request in work plus one waiting response
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3)
        else $error("too many requests outstanding");

    // table never holds more than its capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp_page_count <= PCOUNT_W'(NUM_PAGES))
        else $error("page count beyond capacity");

    // a nonzero page address only comes with success
    a_page_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_page_addr != '0 |-> i_rsp_ok)
        else $error("page address returned on failure");

endmodule : pfba_check

bind page_frame_bitmap_allocator pfba_check u_pfba_check (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_rsp_page_addr  (o_rsp.page_addr),
    .i_rsp_ok         (o_rsp.ok),
    .i_rsp_page_count (o_rsp.page_count)
);
`default_nettype wire
